// ----- src/entropy_pool_twist_mixer_unit_defines.svh -----
// assertion macros for the entropy pool twist mixer
`ifndef ENTROPY_POOL_TWIST_MIXER_UNIT_DEFINES_SVH
`define ENTROPY_POOL_TWIST_MIXER_UNIT_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define EPM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("entropy pool mixer: same-cycle check failed");

// property that must hold in the cycle after its trigger
`define EPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("entropy pool mixer: next-cycle check failed");

`endif

// ----- src/epm_pkg.sv -----
// shared types, constants and the twist table of the entropy pool mixer
`default_nettype none

package epm_pkg;

    localparam int POOL_WORDS = 128;
    localparam int IDX_W      = $clog2(POOL_WORDS);
    localparam int WORD_W     = 32;
    localparam int NUM_TAPS   = 6;

    // tap offsets from the mixing position
    localparam int TAP_A = 1;
    localparam int TAP_B = 25;
    localparam int TAP_C = 51;
    localparam int TAP_D = 76;
    localparam int TAP_E = 103;

    // twist table, entry 0 at the right
    localparam logic [7:0][WORD_W-1:0] TWIST_TAB = {
        32'ha00ae278, 32'h9b64c2b0, 32'hd6d6a3e8, 32'hedb88320,
        32'h4db26158, 32'h76dc4190, 32'h3b6e20c8, 32'h00000000
    };

    typedef enum logic {
        REQ_MIX  = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t         req_type;
        logic [WORD_W-1:0] entropy_word;
        logic [IDX_W-1:0]  read_index;
    } req_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] pool_word;
        logic [IDX_W-1:0]  word_index;
    } rsp_item_t;

    // shifted value xored with the table entry picked by its low bits
    function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] res;
        res = (x >> 3) ^ TWIST_TAB[x[2:0]];
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- src/epm_cell.sv -----
// one pool cell: holds a word and takes its neighbour's word on a mix
`default_nettype none

module epm_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        shift,
    input  wire logic [epm_pkg::WORD_W-1:0]  neighbour_word,
    output logic      [epm_pkg::WORD_W-1:0]  word
);

    logic [epm_pkg::WORD_W-1:0] word_reg;
    logic [epm_pkg::WORD_W-1:0] word_next;

    // hold or take the neighbour's word
    always_comb
    begin
        word_next = shift ? neighbour_word : word_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// ----- src/epm_mix.sv -----
// mixing function: xor of entropy word and six taps, then twist
`default_nettype none

module epm_mix (
    input  wire logic [epm_pkg::WORD_W-1:0]                        entropy_word,
    input  wire logic [epm_pkg::NUM_TAPS-1:0][epm_pkg::WORD_W-1:0] taps,
    output logic      [epm_pkg::WORD_W-1:0]                        mixed_word
);

    logic [epm_pkg::WORD_W-1:0] folded;

    // fold the taps into the entropy word
    always_comb
    begin
        folded = entropy_word;
        for (int t = 0; t < epm_pkg::NUM_TAPS; t++)
        begin
            folded = folded ^ taps[t];
        end
        mixed_word = epm_pkg::twist(folded);
    end

endmodule

`default_nettype wire

// ----- src/epm_out_stage.sv -----
// output register with a skid word that holds one more input word while the output stalls
`default_nettype none

module epm_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire epm_pkg::rsp_item_t load_item,
    output logic                    load_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output epm_pkg::rsp_item_t      rsp
);

    logic               out_valid_reg;
    logic               out_valid_next;
    epm_pkg::rsp_item_t out_reg;
    epm_pkg::rsp_item_t out_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    epm_pkg::rsp_item_t skid_reg;
    epm_pkg::rsp_item_t skid_next;

    // skid word free means a new word can be taken
    assign load_ready = !skid_valid_reg;

    // move words between skid and output registers
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || rsp_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_next       = load_item;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_next       = load_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ----- src/entropy_pool_twist_mixer_unit.sv -----
// a result is registered in the output stage, or in its skid word while the output stalls, once its request is accepted
// throughput: one request per cycle, mix or read, while the skid word is free; the tap xor is combinational
// the pool is a rotating row of 128 cells: cell k holds the word at mixing position + k
// a read selects a cell through a 128-way mux on index minus position
// reset clears all cells and the position at once; requests are taken from the first cycle
`default_nettype none

module entropy_pool_twist_mixer_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire epm_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output epm_pkg::rsp_item_t      rsp
);

`include "entropy_pool_twist_mixer_unit_defines.svh"

    logic [epm_pkg::WORD_W-1:0] cell_word [epm_pkg::POOL_WORDS];
    logic [epm_pkg::NUM_TAPS-1:0][epm_pkg::WORD_W-1:0] taps;
    logic [epm_pkg::WORD_W-1:0] mixed_word;
    logic [epm_pkg::IDX_W-1:0]  mix_pos_reg;
    logic [epm_pkg::IDX_W-1:0]  mix_pos_next;
    logic [epm_pkg::IDX_W-1:0]  cell_sel;
    logic                       accept;
    logic                       mix_go;
    epm_pkg::rsp_item_t         result;

    assign accept = req_valid && req_ready;
    assign mix_go = accept && (req.req_type == epm_pkg::REQ_MIX);

    // fixed taps, cell 0 is the current mixing position
    assign taps[0] = cell_word[0];
    assign taps[1] = cell_word[epm_pkg::TAP_A];
    assign taps[2] = cell_word[epm_pkg::TAP_B];
    assign taps[3] = cell_word[epm_pkg::TAP_C];
    assign taps[4] = cell_word[epm_pkg::TAP_D];
    assign taps[5] = cell_word[epm_pkg::TAP_E];

    epm_mix u_mix (
        .entropy_word (req.entropy_word),
        .taps         (taps),
        .mixed_word   (mixed_word)
    );

    // row of cells, rotating by one on every mix; the new word enters at the far end
    for (genvar k = 0; k < epm_pkg::POOL_WORDS; k++)
    begin : g_cell
        if (k == epm_pkg::POOL_WORDS - 1)
        begin : g_last
            epm_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .shift          (mix_go),
                .neighbour_word (mixed_word),
                .word           (cell_word[k])
            );
        end
        else
        begin : g_mid
            epm_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .shift          (mix_go),
                .neighbour_word (cell_word[k+1]),
                .word           (cell_word[k])
            );
        end
    end

    // mixing position
    assign mix_pos_next = mix_go ? mix_pos_reg + 1'b1 : mix_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_pos_reg <= '0;
        end
        else
        begin
            mix_pos_reg <= mix_pos_next;
        end
    end

    // result word: new word on mix, selected cell on read
    assign cell_sel = req.read_index - mix_pos_reg;

    always_comb
    begin
        if (req.req_type == epm_pkg::REQ_MIX)
        begin
            result.pool_word  = mixed_word;
            result.word_index = mix_pos_reg;
        end
        else
        begin
            result.pool_word  = cell_word[cell_sel];
            result.word_index = req.read_index;
        end
    end

    epm_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .load_item  (result),
        .load_ready (req_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    // checks
    `EPM_ASSERT_NEXT(a_pos_advance, mix_go, mix_pos_reg == $past(mix_pos_reg) + 1'b1)
    `EPM_ASSERT_NEXT(a_read_keeps_pos, accept && !mix_go, $stable(mix_pos_reg))
    `EPM_ASSERT_NOW(a_stall_only_when_full, !req_ready, rsp_valid)
    `EPM_ASSERT_NEXT(a_mix_written_back, mix_go && (!rsp_valid || rsp_ready),
        rsp_valid && rsp.pool_word == cell_word[epm_pkg::POOL_WORDS-1]
        && rsp.word_index == $past(mix_pos_reg))

endmodule

`default_nettype wire

// ----- verif/entropy_pool_twist_mixer_unit_tb.sv -----
// testbench for the entropy pool twist mixer: directed table then random words on a shadow pool
module entropy_pool_twist_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // twist values picked by the low three bits of the folded word, entry 0 at the right
    localparam logic [7:0][31:0] TWIST_XOR = {
        32'ha00ae278, 32'h9b64c2b0, 32'hd6d6a3e8, 32'hedb88320,
        32'h4db26158, 32'h76dc4190, 32'h3b6e20c8, 32'h00000000
    };
    localparam int RANDOM_WORDS  = 1750;
    localparam int HOLD_CYCLES   = 250;

    typedef struct {
        epm_pkg::req_item_t item;
        bit                 typed;
        epm_pkg::rsp_item_t want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    epm_pkg::req_item_t req = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    epm_pkg::rsp_item_t rsp;

    // shadow of the pool and the mixing position
    logic [31:0] pool_shadow [128];
    logic [6:0]  mix_pos;

    epm_pkg::rsp_item_t pool_word_due_q [$];
    dir_row_t           dir_rows [$];
    int                 fail_cnt = 0;
    int                 words_checked = 0;
    bit                 send_calm = 1'b0;

    entropy_pool_twist_mixer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // fold a word into the shadow pool, or look one up
    function automatic epm_pkg::rsp_item_t next_pool_word(input epm_pkg::req_item_t item);
        logic [31:0]        acc;
        epm_pkg::rsp_item_t res;
        if (item.req_type == epm_pkg::REQ_MIX)
        begin
            acc = item.entropy_word ^ pool_shadow[mix_pos]
                ^ pool_shadow[mix_pos + 7'd1] ^ pool_shadow[mix_pos + 7'd25]
                ^ pool_shadow[mix_pos + 7'd51] ^ pool_shadow[mix_pos + 7'd76]
                ^ pool_shadow[mix_pos + 7'd103];
            acc = (acc >> 3) ^ TWIST_XOR[acc[2:0]];
            pool_shadow[mix_pos] = acc;
            res.pool_word = acc;
            res.word_index = mix_pos;
            mix_pos = mix_pos + 7'd1;
        end
        else
        begin
            res.pool_word = pool_shadow[item.read_index];
            res.word_index = item.read_index;
        end
        return res;
    endfunction

    function automatic void add_row(input epm_pkg::req_kind_t kind, input logic [31:0] ent,
                                    input logic [6:0] idx, input bit typed,
                                    input logic [31:0] want_word, input logic [6:0] want_idx);
        dir_row_t row;
        row.item = '{req_type: kind, entropy_word: ent, read_index: idx};
        row.typed = typed;
        row.want = '{pool_word: want_word, word_index: want_idx};
        dir_rows.push_back(row);
    endfunction

    // offer one request word and hold it until taken
    task automatic offer_word(input epm_pkg::req_item_t item, input bit typed,
                              input epm_pkg::rsp_item_t want);
        epm_pkg::rsp_item_t predicted;
        if (!send_calm && $urandom_range(99) < 20)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 20)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = next_pool_word(item);
        pool_word_due_q.push_back(typed ? want : predicted);
    endtask

    // request side: reset, directed table, random words, drain
    initial
    begin : req_side
        epm_pkg::req_item_t item;
        epm_pkg::rsp_item_t none;
        int                 pick;
        int                 drain_wait;
        for (int k = 0; k < 128; k++)
            pool_shadow[k] = '0;
        mix_pos = '0;
        none = '0;

        // reads of the cleared pool, ignored fields set to extremes
        add_row(epm_pkg::REQ_READ, 32'h0000_0000, 7'd0,   1'b1, 32'h0000_0000, 7'd0);
        add_row(epm_pkg::REQ_READ, 32'hffff_ffff, 7'd127, 1'b1, 32'h0000_0000, 7'd127);
        // first mixes over a zero pool
        add_row(epm_pkg::REQ_MIX,  32'h0000_0000, 7'd127, 1'b1, 32'h0000_0000, 7'd0);
        add_row(epm_pkg::REQ_MIX,  32'hffff_ffff, 7'd0,   1'b1, 32'hbff5_1d87, 7'd1);
        add_row(epm_pkg::REQ_READ, 32'h1234_5678, 7'd1,   1'b1, 32'hbff5_1d87, 7'd1);
        // every twist entry, taps still clear at these positions
        for (int k = 0; k < 8; k++)
            add_row(epm_pkg::REQ_MIX, 32'(k), 7'(k * 16), 1'b1, TWIST_XOR[k], 7'(k + 2));
        add_row(epm_pkg::REQ_MIX,  32'h8000_0000, 7'd0,   1'b1, 32'h1000_0000, 7'd10);
        add_row(epm_pkg::REQ_READ, 32'hdead_beef, 7'd127, 1'b1, 32'h0000_0000, 7'd127);
        // read after read leaves the pool alone; then two mixes and reads at 11 and 10, checked on the shadow
        add_row(epm_pkg::REQ_READ, 32'h0000_0000, 7'd5,   1'b0, 32'h0, 7'd0);
        add_row(epm_pkg::REQ_READ, 32'hffff_ffff, 7'd5,   1'b0, 32'h0, 7'd0);
        add_row(epm_pkg::REQ_MIX,  32'hdead_beef, 7'd127, 1'b0, 32'h0, 7'd0);
        add_row(epm_pkg::REQ_MIX,  32'h5555_aaaa, 7'd64,  1'b0, 32'h0, 7'd0);
        add_row(epm_pkg::REQ_READ, 32'h0000_0000, 7'd11,  1'b0, 32'h0, 7'd0);
        add_row(epm_pkg::REQ_READ, 32'h0000_0000, 7'd10,  1'b0, 32'h0, 7'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
            offer_word(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        // random mixes and reads, with a calm stretch in the middle
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            send_calm = (n >= 700 && n < 1000);
            item.req_type = ($urandom_range(99) < 70) ? epm_pkg::REQ_MIX : epm_pkg::REQ_READ;
            pick = $urandom_range(15);
            if (pick == 0)
                item.entropy_word = 32'h0000_0000;
            else if (pick == 1)
                item.entropy_word = 32'hffff_ffff;
            else
                item.entropy_word = $urandom;
            item.read_index = 7'($urandom_range(127));
            offer_word(item, 1'b0, none);
        end
        req_valid <= 1'b0;

        // wait for outstanding words, then the pipeline latency
        drain_wait = 0;
        while (pool_word_due_q.size() != 0 && drain_wait < 2000)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (4) @(posedge clk);
        if (pool_word_due_q.size() != 0)
        begin
            $display("%0t ns: %0d expected words never arrived", $time,
                     pool_word_due_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // response side: check each word, random stalls and one long hold-off
    initial
    begin : rsp_side
        epm_pkg::rsp_item_t want;
        int                 hold_left;
        bit                 held_once;
        bit                 calm;
        hold_left = 0;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (pool_word_due_q.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none, actual %h index %0d",
                             $time, rsp.pool_word, rsp.word_index);
                    fail_cnt++;
                end
                else
                begin
                    want = pool_word_due_q.pop_front();
                    if (rsp.pool_word !== want.pool_word)
                    begin
                        $display("%0t ns: pool_word expected %h actual %h", $time,
                                 want.pool_word, rsp.pool_word);
                        fail_cnt++;
                    end
                    if (rsp.word_index !== want.word_index)
                    begin
                        $display("%0t ns: word_index expected %0d actual %0d", $time,
                                 want.word_index, rsp.word_index);
                        fail_cnt++;
                    end
                end
                words_checked++;
            end
            calm = (words_checked >= 800 && words_checked < 1100);
            // long hold-off so the block fills and backs up its input
            if (!held_once && words_checked >= 400)
            begin
                hold_left = HOLD_CYCLES;
                held_once = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (calm)
                rsp_ready <= 1'b1;
            else
                rsp_ready <= ($urandom_range(99) >= 20);
        end
    end

    // guard against a hung handshake
    initial
    begin : watchdog
        #1_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
